>>> sv/bds_pkg.sv
package bds_pkg;

  localparam int MAX_ITEMS  = 256;
  localparam int MAX_DISKS  = 8;
  localparam int PAGE_BITS  = 16;
  localparam int PROB_BITS  = 16;
  localparam int ADDR_BITS  = 8;
  localparam int CNT_BITS   = 9;
  localparam int DISK_BITS  = 3;
  localparam int DCNT_BITS  = 4;
  localparam int SLOT_BITS  = 32;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_BUILD = 2'd1;
  localparam logic [1:0] MODE_EMIT  = 2'd2;

  localparam logic [2:0] ST_LOADED    = 3'd0;
  localparam logic [2:0] ST_BUILT     = 3'd1;
  localparam logic [2:0] ST_EMITTED   = 3'd2;
  localparam logic [2:0] ST_ERROR     = 3'd3;
  localparam logic [2:0] ST_NOT_READY = 3'd4;

  typedef struct packed {
    logic [1:0]           mode;
    logic [PAGE_BITS-1:0] page_id;
    logic [PROB_BITS-1:0] hit_prob;
  } bds_in_t;

  typedef struct packed {
    logic [2:0]           status;
    logic [PAGE_BITS-1:0] page_out;
    logic [DISK_BITS-1:0] disk_out;
    logic                 chunk_last;
    logic                 cycle_last;
  } bds_res_t;

  typedef enum logic [4:0] {
    S_IDLE, S_LD_RD, S_LD_CMP, S_LD_WR, S_SORT, S_FQ_INIT, S_FQ_MUL, S_FQ_CMP,
    S_GCD, S_LQ, S_LCHK, S_GR_INIT, S_GR_RD, S_GR_CMP, S_GR_END, S_CH_START,
    S_CH_CLAMP, S_CH_DIV, S_CH_CHK, S_NEXT_R, S_FIN, S_SKIP, S_EM, S_DIV
  } bds_state_e;

endpackage

>>> sv/broadcast_disk_scheduler.sv
// Broadcast disk scheduler.
// Command channel: drive in_i and raise start_i; an item is taken at a rising
// edge where start_i is high and busy_o is low. Every item gives one result on
// res_o, marked by done_o for exactly one cycle; the receiver cannot stall it.
// Refused and not-ready items: result in the cycle after the item is taken.
// Load item: scans the stored pages, a read state then a compare state per
//   page, and stops at a match or the last page, then writes.
// Emit item: grouped page memory read, then result inside a chunk; for the
//   last page of a chunk the result comes from the skip state, after it
//   steps over any empty disks that follow.
// Build item: odd-even sort of the disk table, then per disk a frequency
//   search on its own multiplier, gcd and lcm on the shared 32-step
//   restoring divider, a page selection pass over all items per placed
//   page, and chunk fitting by trial division. The page selection over the
//   single item memory port sets its length.
// Reset clears all counters, flags and the schedule; page memories hold
// garbage until written and their contents are never used before that.
module broadcast_disk_scheduler
  import bds_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  bds_in_t  in_i,
  output logic     busy_o,
  output logic     done_o,
  output bds_res_t res_o
);

  bds_state_e state_q, state_d, ret_q;

  bds_in_t in_q;

  // item and grouped page memories
  logic [PAGE_BITS-1:0] pg_mem  [MAX_ITEMS];
  logic [PROB_BITS-1:0] pr_mem  [MAX_ITEMS];
  logic [PAGE_BITS-1:0] grp_mem [MAX_ITEMS];
  logic [PAGE_BITS-1:0] pg_rd_q, grp_rd_q;
  logic [PROB_BITS-1:0] pr_rd_q;

  logic [CNT_BITS-1:0]  idx_q, total_q, pos_q, n_q, pc_q;
  logic [ADDR_BITS-1:0] at_q;
  logic                 found_q;
  logic [DCNT_BITS-1:0] du_q;
  logic [PROB_BITS-1:0] dp_q    [MAX_DISKS];
  logic [CNT_BITS-1:0]  sizes_q [MAX_DISKS];
  logic [CNT_BITS-1:0]  freq_q  [MAX_DISKS];
  logic [CNT_BITS-1:0]  cs_q    [MAX_DISKS];
  logic [CNT_BITS-1:0]  base_q  [MAX_DISKS];
  logic [CNT_BITS-1:0]  off_q   [MAX_DISKS];
  logic [SLOT_BITS-1:0] slots_q, slot_q, c_q;
  logic [DISK_BITS-1:0] dc_q, r_q, srt_q, disk_res_q;
  logic                 built_q, wrap_q, skip_emit_q;
  logic [PROB_BITS-1:0] pmin_q;
  logic [CNT_BITS-1:0]  f_q;
  logic [16:0]          f2_q;
  logic [40:0]          prod_q;
  logic [PAGE_BITS-1:0] last_q, best_q, page_res_q;
  logic                 last_v_q, best_v_q;

  // shared restoring divider
  logic [SLOT_BITS:0]   div_rem_q;
  logic [SLOT_BITS-1:0] div_quo_q, div_den_q;
  logic [5:0]           div_cnt_q;

  bds_res_t res_q;
  logic     done_q;

  // combinational helpers
  logic                 have_disk, ld_match, idx_end, r_end, em_last, cur_empty, div_last;
  logic                 fq_lt, gr_take, ovf;
  logic [ADDR_BITS-1:0] ld_at;
  logic [9:0]           em_idx;
  logic [SLOT_BITS:0]   div_sh;
  logic [DCNT_BITS-1:0] dc_inc;
  logic                 disk_wrap, nd_wrap;
  logic [SLOT_BITS:0]   slot_inc;
  logic [DISK_BITS-1:0] nd_dc;
  logic [SLOT_BITS-1:0] nd_slot;
  logic [32:0]          fq_mul;
  logic [40:0]          lq_mul;
  logic                 pg_we, pr_we, grp_we;
  logic [ADDR_BITS-1:0] item_wa;
  logic [ADDR_BITS-1:0] grp_raddr;

  always_comb begin
    have_disk = 1'b0;
    for (int j = 0; j < MAX_DISKS; j++) begin
      if ((DCNT_BITS'(j) < du_q) && (dp_q[j] == in_q.hit_prob)) have_disk = 1'b1;
    end
  end

  assign ld_match  = (pg_rd_q == in_q.page_id);
  assign idx_end   = ((idx_q + CNT_BITS'(1)) == total_q);
  assign r_end     = (({1'b0, r_q} + DCNT_BITS'(1)) == du_q);
  assign em_last   = (({1'b0, pc_q} + 10'd1) >= {1'b0, cs_q[dc_q]});
  assign cur_empty = (cs_q[dc_q] == '0);
  assign div_last  = (div_cnt_q == 6'd1);
  assign fq_lt     = (prod_q < {25'd0, dp_q[r_q]});
  assign ovf       = (prod_q[40:32] != '0);
  assign gr_take   = (pr_rd_q == dp_q[r_q]) && (!last_v_q || (pg_rd_q > last_q)) &&
                     (!best_v_q || (pg_rd_q < best_q));
  assign ld_at     = found_q ? at_q : total_q[ADDR_BITS-1:0];
  assign em_idx    = {1'b0, base_q[dc_q]} + {1'b0, off_q[dc_q]} + {1'b0, pc_q};
  assign div_sh    = {div_rem_q[SLOT_BITS-1:0], div_quo_q[SLOT_BITS-1]};
  assign fq_mul    = f2_q * pmin_q;
  assign lq_mul    = div_quo_q * f_q;

  // next disk in rank order, slot advance and cycle wrap
  assign dc_inc    = {1'b0, dc_q} + DCNT_BITS'(1);
  assign disk_wrap = (dc_inc >= du_q);
  assign nd_dc     = disk_wrap ? '0 : dc_inc[DISK_BITS-1:0];
  assign slot_inc  = {1'b0, slot_q} + 33'd1;
  assign nd_wrap   = disk_wrap && (slot_inc >= {1'b0, slots_q});
  assign nd_slot   = nd_wrap ? '0 : (disk_wrap ? slot_inc[SLOT_BITS-1:0] : slot_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          unique case (in_i.mode)
            MODE_LOAD: begin
              if (in_i.hit_prob == '0) state_d = S_IDLE;
              else if (total_q == '0)  state_d = S_LD_WR;
              else                     state_d = S_LD_RD;
            end
            MODE_BUILD: state_d = (total_q == '0) ? S_IDLE : S_SORT;
            MODE_EMIT:  state_d = built_q ? S_EM : S_IDLE;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_LD_RD:    state_d = S_LD_CMP;
      S_LD_CMP:   state_d = (ld_match || idx_end) ? S_LD_WR : S_LD_RD;
      S_LD_WR:    state_d = S_IDLE;
      S_SORT:     state_d = (srt_q == DISK_BITS'(MAX_DISKS - 1)) ? S_FQ_INIT : S_SORT;
      S_FQ_INIT:  state_d = S_FQ_MUL;
      S_FQ_MUL:   state_d = S_FQ_CMP;
      S_FQ_CMP:   state_d = fq_lt ? S_FQ_MUL : S_DIV;
      S_DIV:      state_d = div_last ? ret_q : S_DIV;
      S_GCD:      state_d = S_DIV;
      S_LQ:       state_d = S_LCHK;
      S_LCHK: begin
        if (ovf)        state_d = S_IDLE;
        else if (r_end) state_d = S_GR_INIT;
        else            state_d = S_FQ_INIT;
      end
      S_GR_INIT:  state_d = S_GR_RD;
      S_GR_RD:    state_d = S_GR_CMP;
      S_GR_CMP:   state_d = idx_end ? S_GR_END : S_GR_RD;
      S_GR_END:   state_d = best_v_q ? S_GR_RD : S_CH_START;
      S_CH_START: state_d = (n_q == '0) ? S_NEXT_R : S_DIV;
      S_CH_CLAMP: state_d = S_CH_DIV;
      S_CH_DIV:   state_d = S_DIV;
      S_CH_CHK:   state_d = (div_rem_q != '0) ? S_CH_DIV : S_NEXT_R;
      S_NEXT_R:   state_d = r_end ? S_FIN : S_GR_INIT;
      S_FIN:      state_d = S_SKIP;
      S_SKIP:     state_d = cur_empty ? S_SKIP : S_IDLE;
      S_EM:       state_d = em_last ? S_SKIP : S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // outputs and memory controls
  always_comb begin
    busy_o    = (state_q != S_IDLE);
    pg_we     = 1'b0;
    pr_we     = 1'b0;
    grp_we    = 1'b0;
    item_wa   = ld_at;
    grp_raddr = em_idx[ADDR_BITS-1:0];
    unique case (state_q)
      S_LD_WR: begin
        if (!(!have_disk && (du_q >= DCNT_BITS'(MAX_DISKS))) &&
            !(!found_q && (total_q >= CNT_BITS'(MAX_ITEMS)))) begin
          pg_we = !found_q;
          pr_we = 1'b1;
        end
      end
      S_GR_END: grp_we = best_v_q;
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  always_ff @(posedge clk_i) begin
    if (pg_we) pg_mem[item_wa] <= in_q.page_id;
    if (pr_we) pr_mem[item_wa] <= in_q.hit_prob;
    pg_rd_q <= pg_mem[idx_q[ADDR_BITS-1:0]];
    pr_rd_q <= pr_mem[idx_q[ADDR_BITS-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (grp_we) grp_mem[pos_q[ADDR_BITS-1:0]] <= best_q;
    grp_rd_q <= grp_mem[grp_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      in_q        <= '0;
      idx_q       <= '0;
      total_q     <= '0;
      pos_q       <= '0;
      n_q         <= '0;
      pc_q        <= '0;
      at_q        <= '0;
      found_q     <= 1'b0;
      du_q        <= '0;
      for (int j = 0; j < MAX_DISKS; j++) begin
        dp_q[j]    <= '0;
        sizes_q[j] <= '0;
        freq_q[j]  <= '0;
        cs_q[j]    <= '0;
        base_q[j]  <= '0;
        off_q[j]   <= '0;
      end
      slots_q     <= '0;
      slot_q      <= '0;
      c_q         <= '0;
      dc_q        <= '0;
      r_q         <= '0;
      srt_q       <= '0;
      disk_res_q  <= '0;
      built_q     <= 1'b0;
      wrap_q      <= 1'b0;
      skip_emit_q <= 1'b0;
      pmin_q      <= '0;
      f_q         <= '0;
      f2_q        <= '0;
      prod_q      <= '0;
      last_q      <= '0;
      best_q      <= '0;
      page_res_q  <= '0;
      last_v_q    <= 1'b0;
      best_v_q    <= 1'b0;
      div_rem_q   <= '0;
      div_quo_q   <= '0;
      div_den_q   <= '0;
      div_cnt_q   <= '0;
      res_q       <= '0;
      done_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            in_q    <= in_i;
            idx_q   <= '0;
            found_q <= 1'b0;
            res_q   <= '0;
            unique case (in_i.mode)
              MODE_LOAD: begin
                if (in_i.hit_prob == '0) begin
                  res_q.status <= ST_ERROR;
                  done_q       <= 1'b1;
                end
              end
              MODE_BUILD: begin
                if (total_q == '0) begin
                  res_q.status <= ST_NOT_READY;
                  done_q       <= 1'b1;
                end else begin
                  srt_q   <= '0;
                  slots_q <= SLOT_BITS'(1);
                  r_q     <= '0;
                end
              end
              MODE_EMIT: begin
                if (!built_q) begin
                  res_q.status <= ST_NOT_READY;
                  done_q       <= 1'b1;
                end
              end
              default: begin
                res_q.status <= ST_NOT_READY;
                done_q       <= 1'b1;
              end
            endcase
          end
        end
        S_LD_CMP: begin
          if (ld_match) begin
            found_q <= 1'b1;
            at_q    <= idx_q[ADDR_BITS-1:0];
          end else begin
            idx_q <= idx_q + CNT_BITS'(1);
          end
        end
        S_LD_WR: begin
          res_q  <= '0;
          done_q <= 1'b1;
          if ((!have_disk && (du_q >= DCNT_BITS'(MAX_DISKS))) ||
              (!found_q && (total_q >= CNT_BITS'(MAX_ITEMS)))) begin
            res_q.status <= ST_ERROR;
          end else begin
            res_q.status <= ST_LOADED;
            if (!have_disk) begin
              dp_q[du_q[DISK_BITS-1:0]] <= in_q.hit_prob;
              du_q <= du_q + DCNT_BITS'(1);
            end
            if (!found_q) total_q <= total_q + CNT_BITS'(1);
            built_q <= 1'b0;
          end
        end
        S_SORT: begin
          // odd-even transposition, highest probability first
          for (int j = 0; j < MAX_DISKS - 1; j++) begin
            if ((j[0] == srt_q[0]) && (DCNT_BITS'(j + 1) < du_q) &&
                (dp_q[j] < dp_q[j+1])) begin
              dp_q[j]   <= dp_q[j+1];
              dp_q[j+1] <= dp_q[j];
            end
          end
          srt_q <= srt_q + DISK_BITS'(1);
        end
        S_FQ_INIT: begin
          pmin_q <= dp_q[du_q[DISK_BITS-1:0] - DISK_BITS'(1)];
          f_q    <= CNT_BITS'(1);
          f2_q   <= 17'd1;
        end
        S_FQ_MUL: prod_q <= {8'd0, fq_mul};
        S_FQ_CMP: begin
          if (fq_lt) begin
            f_q  <= f_q + CNT_BITS'(1);
            f2_q <= f2_q + {7'd0, f_q, 1'b0} + 17'd1;
          end else begin
            div_rem_q <= '0;
            div_quo_q <= slots_q;
            div_den_q <= {23'd0, f_q};
            div_cnt_q <= 6'd32;
            ret_q     <= S_GCD;
          end
        end
        S_DIV: begin
          if (div_sh >= {1'b0, div_den_q}) begin
            div_rem_q <= div_sh - {1'b0, div_den_q};
            div_quo_q <= {div_quo_q[SLOT_BITS-2:0], 1'b1};
          end else begin
            div_rem_q <= div_sh;
            div_quo_q <= {div_quo_q[SLOT_BITS-2:0], 1'b0};
          end
          div_cnt_q <= div_cnt_q - 6'd1;
        end
        S_GCD: begin
          // Euclid step; on a zero remainder divide slots by the gcd
          div_cnt_q <= 6'd32;
          div_rem_q <= '0;
          if (div_rem_q == '0) begin
            div_quo_q <= slots_q;
            ret_q     <= S_LQ;
          end else begin
            div_quo_q <= div_den_q;
            div_den_q <= div_rem_q[SLOT_BITS-1:0];
            ret_q     <= S_GCD;
          end
        end
        S_LQ: prod_q <= lq_mul;
        S_LCHK: begin
          if (ovf) begin
            res_q        <= '0;
            res_q.status <= ST_ERROR;
            done_q       <= 1'b1;
          end else begin
            slots_q   <= prod_q[SLOT_BITS-1:0];
            freq_q[r_q] <= f_q;
            if (r_end) begin
              r_q   <= '0;
              pos_q <= '0;
            end else begin
              r_q <= r_q + DISK_BITS'(1);
            end
          end
        end
        S_GR_INIT: begin
          base_q[r_q] <= pos_q;
          n_q         <= '0;
          idx_q       <= '0;
          last_v_q    <= 1'b0;
          best_v_q    <= 1'b0;
        end
        S_GR_CMP: begin
          if (gr_take) begin
            best_q   <= pg_rd_q;
            best_v_q <= 1'b1;
          end
          if (!idx_end) idx_q <= idx_q + CNT_BITS'(1);
        end
        S_GR_END: begin
          if (best_v_q) begin
            pos_q    <= pos_q + CNT_BITS'(1);
            n_q      <= n_q + CNT_BITS'(1);
            last_q   <= best_q;
            last_v_q <= 1'b1;
            best_v_q <= 1'b0;
            idx_q    <= '0;
          end
        end
        S_CH_START: begin
          sizes_q[r_q] <= n_q;
          if (n_q == '0) begin
            cs_q[r_q] <= '0;
          end else begin
            div_rem_q <= '0;
            div_quo_q <= slots_q;
            div_den_q <= {23'd0, freq_q[r_q]};
            div_cnt_q <= 6'd32;
            ret_q     <= S_CH_CLAMP;
          end
        end
        S_CH_CLAMP: c_q <= (div_quo_q > {23'd0, n_q}) ? {23'd0, n_q} : div_quo_q;
        S_CH_DIV: begin
          div_rem_q <= '0;
          div_quo_q <= {23'd0, n_q};
          div_den_q <= c_q;
          div_cnt_q <= 6'd32;
          ret_q     <= S_CH_CHK;
        end
        S_CH_CHK: begin
          if (div_rem_q != '0) c_q <= c_q - SLOT_BITS'(1);
          else                 cs_q[r_q] <= div_quo_q[CNT_BITS-1:0];
        end
        S_NEXT_R: begin
          if (!r_end) r_q <= r_q + DISK_BITS'(1);
        end
        S_FIN: begin
          slot_q      <= '0;
          dc_q        <= '0;
          pc_q        <= '0;
          wrap_q      <= 1'b0;
          skip_emit_q <= 1'b0;
          for (int j = 0; j < MAX_DISKS; j++) off_q[j] <= '0;
        end
        S_SKIP, S_EM: begin
          if ((state_q == S_SKIP && cur_empty) || (state_q == S_EM && em_last)) begin
            // advance to the next disk, and the next slot after the last disk
            dc_q   <= nd_dc;
            slot_q <= nd_slot;
            if (disk_wrap) begin
              for (int j = 0; j < MAX_DISKS; j++) begin
                if (nd_wrap ||
                    (({1'b0, off_q[j]} + {1'b0, cs_q[j]}) >= {1'b0, sizes_q[j]})) begin
                  off_q[j] <= '0;
                end else begin
                  off_q[j] <= off_q[j] + cs_q[j];
                end
              end
            end
          end
          if (state_q == S_EM) begin
            page_res_q <= grp_rd_q;
            disk_res_q <= dc_q;
            if (em_last) begin
              pc_q        <= '0;
              wrap_q      <= nd_wrap;
              skip_emit_q <= 1'b1;
            end else begin
              pc_q               <= pc_q + CNT_BITS'(1);
              res_q              <= '0;
              res_q.status       <= ST_EMITTED;
              res_q.page_out     <= grp_rd_q;
              res_q.disk_out     <= dc_q;
              done_q             <= 1'b1;
            end
          end else if (cur_empty) begin
            wrap_q <= wrap_q | nd_wrap;
          end else begin
            res_q  <= '0;
            done_q <= 1'b1;
            if (skip_emit_q) begin
              res_q.status     <= ST_EMITTED;
              res_q.page_out   <= page_res_q;
              res_q.disk_out   <= disk_res_q;
              res_q.chunk_last <= 1'b1;
              res_q.cycle_last <= wrap_q;
            end else begin
              res_q.status <= ST_BUILT;
              built_q      <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  a_du_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    du_q <= DCNT_BITS'(MAX_DISKS)) else $error("disk count past table size");

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CNT_BITS'(MAX_ITEMS)) else $error("item count past table size");

  a_cursor_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (built_q && state_q == S_IDLE) |-> (cs_q[dc_q] != '0))
    else $error("schedule cursor rests on an empty disk");

  a_page_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (built_q && state_q == S_IDLE) |-> (pc_q < cs_q[dc_q]))
    else $error("page cursor past chunk end");

  a_div_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (div_den_q != '0)) else $error("divide by zero");

endmodule
